FILE: src/life_generation_stream_macros.svh
`ifndef LIFE_GENERATION_STREAM_MACROS_SVH
`define LIFE_GENERATION_STREAM_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define LGS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define LGS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/lgs_pkg.sv
`timescale 1ns / 1ps

package lgs_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_DIM    = 3;
  localparam int RESET_DIM  = 64;

  // column index, register and row widths
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  // scan row runs into the flush rows past the frame
  localparam int RPW = $clog2(MAX_HEIGHT + 3);

  localparam int CELL_W = 2;
  localparam int WIN_W  = 9;

  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_PW    = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CW    = $clog2(OFIFO_DEPTH + 1);

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic cell_alive;
    logic drain;
  } in_item_t;

  typedef struct packed {
    logic          next_alive;
    logic [CW-1:0] column;
    logic [RW-1:0] row;
    logic          frame_last;
  } out_item_t;

  typedef struct packed {
    logic [WW-1:0] grid_width;
    logic [HW-1:0] grid_height;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [CW-1:0]     addr;
    logic [CELL_W-1:0] data;
  } line_wr_t;

  // per-cell tag carried from the scan into the update stage
  typedef struct packed {
    logic          v;
    logic [CW-1:0] addr;
    logic          has;
    logic          at_edge;
    logic          interior;
    logic          last;
    logic [CW-1:0] ocol;
    logic [RW-1:0] orow;
  } s1_t;

  function automatic logic [WW-1:0] clamp_width(input logic [WW-1:0] v);
    logic [WW-1:0] r;
    r = v;
    if (v < WW'(MIN_DIM)) r = WW'(MIN_DIM);
    else if (v > WW'(MAX_WIDTH)) r = WW'(MAX_WIDTH);
    return r;
  endfunction

  function automatic logic [HW-1:0] clamp_height(input logic [HW-1:0] v);
    logic [HW-1:0] r;
    r = v;
    if (v < HW'(MIN_DIM)) r = HW'(MIN_DIM);
    else if (v > HW'(MAX_HEIGHT)) r = HW'(MAX_HEIGHT);
    return r;
  endfunction

  function automatic logic [3:0] neighbor_count(input logic [WIN_W-1:0] win);
    logic [3:0] n;
    n = '0;
    for (int b = 0; b < WIN_W; b++) begin
      if (b != WIN_W / 2) n = n + 4'(win[b]);
    end
    return n;
  endfunction

endpackage

FILE: src/life_generation_stream.sv
`timescale 1ns / 1ps

// Streaming B3/S23 life update, one cell per clock unless stalled. Cells of a generation
// enter in raster order; each accepted request reports the cell one row and one cell
// behind it, so after the W*H cells of a frame W+1 drain requests push out the rest (drain
// requests during the frame are dropped). A request is registered into the update stage
// and its result then into the result queue. The rate is set by the line memory: one read
// at the cell's column, one at the reported column, and one write back per cell, with
// write-first bypass for back-to-back use of one column. A fill mark makes never-written
// columns read as dead, so no clearing pass runs after reset. A four-entry result queue
// takes up output stalls; input stall rises while it can not absorb two more results.
module life_generation_stream (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lgs_pkg::ADDR_W-1:0] paddr,
  input  logic [lgs_pkg::DATA_W-1:0] pwdata,
  output logic [lgs_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  lgs_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output lgs_pkg::out_item_t         out_data_o
);

  localparam int NW = lgs_pkg::OFIFO_CW;

  lgs_pkg::cfg_t              cfg;
  logic                       accept;
  logic                       ren;
  logic [lgs_pkg::CW-1:0]     raddr, eaddr;
  logic                       s1_valid;
  lgs_pkg::s1_t               s1;
  lgs_pkg::line_wr_t          wr;
  logic [lgs_pkg::CELL_W-1:0] rdata, edata;
  logic [lgs_pkg::WIN_W-1:0]  window_q, window_d;
  logic [3:0]                 nbr;
  lgs_pkg::out_item_t         res;
  logic [NW-1:0]              fifo_count;
  logic [NW:0]                pending;

  assign accept = in_valid_i && !in_stall_o;

  lgs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lgs_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .accept_i   (accept),
    .item_i     (in_data_i),
    .ren_o      (ren),
    .raddr_o    (raddr),
    .eaddr_o    (eaddr),
    .s1_valid_o (s1_valid),
    .s1_o       (s1)
  );

  lgs_line_mem u_line_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ren_i   (ren),
    .raddr_i (raddr),
    .eaddr_i (eaddr),
    .wr_i    (wr),
    .rdata_o (rdata),
    .edata_o (edata)
  );

  // column entry: bit1 two rows up, bit0 one row up
  assign wr.we   = s1_valid;
  assign wr.addr = s1.addr;
  assign wr.data = {rdata[0], s1.v};

  // new column enters at the top, oldest column leaves at the bottom
  assign window_d = {s1.v, rdata[0], rdata[1], window_q[lgs_pkg::WIN_W-1:3]};
  assign nbr      = lgs_pkg::neighbor_count(window_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       window_q <= '0;
    else if (s1_valid) window_q <= window_d;
  end

  always_comb begin
    res.column     = s1.ocol;
    res.row        = s1.orow;
    res.frame_last = s1.last;
    if (s1.at_edge)       res.next_alive = edata[1];
    else if (s1.interior) res.next_alive = (nbr == 4'd3) ||
                                           (window_d[lgs_pkg::WIN_W/2] && nbr == 4'd2);
    else                  res.next_alive = window_d[lgs_pkg::WIN_W/2];
  end

  lgs_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s1_valid && s1.has),
    .data_i  (res),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o),
    .count_o (fifo_count)
  );

  // queued results plus the one in flight must leave room for two more
  assign pending    = {1'b0, fifo_count} + (NW + 1)'(s1_valid);
  assign in_stall_o = pending >= (NW + 1)'(lgs_pkg::OFIFO_DEPTH - 1);

endmodule

FILE: src/lgs_regs.sv
`timescale 1ns / 1ps

module lgs_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lgs_pkg::ADDR_W-1:0] paddr,
  input  logic [lgs_pkg::DATA_W-1:0] pwdata,
  output logic [lgs_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output lgs_pkg::cfg_t             cfg_o
);

  logic [lgs_pkg::WW-1:0] width_q, width_d;
  logic [lgs_pkg::HW-1:0] height_q, height_d;
  lgs_pkg::reg_idx_e      idx;
  logic                   wr_en;

  assign pready = 1'b1;
  assign idx    = lgs_pkg::reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    prdata   = '0;
    unique case (idx)
      lgs_pkg::REG_GRID_WIDTH: begin
        prdata = lgs_pkg::DATA_W'(width_q);
        if (wr_en) width_d = pwdata[lgs_pkg::WW-1:0];
      end
      lgs_pkg::REG_GRID_HEIGHT: begin
        prdata = lgs_pkg::DATA_W'(height_q);
        if (wr_en) height_d = pwdata[lgs_pkg::HW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lgs_pkg::WW'(lgs_pkg::RESET_DIM);
      height_q <= lgs_pkg::HW'(lgs_pkg::RESET_DIM);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign cfg_o.grid_width  = width_q;
  assign cfg_o.grid_height = height_q;

endmodule

FILE: src/lgs_scan.sv
`timescale 1ns / 1ps

module lgs_scan (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lgs_pkg::cfg_t          cfg_i,
  input  logic                   accept_i,
  input  lgs_pkg::in_item_t      item_i,
  output logic                   ren_o,
  output logic [lgs_pkg::CW-1:0] raddr_o,
  output logic [lgs_pkg::CW-1:0] eaddr_o,
  output logic                   s1_valid_o,
  output lgs_pkg::s1_t           s1_o
);

  localparam int CW  = lgs_pkg::CW;
  localparam int WW  = lgs_pkg::WW;
  localparam int RW  = lgs_pkg::RW;
  localparam int RPW = lgs_pkg::RPW;

  logic [CW-1:0]  col_q, col_d;
  logic [RPW-1:0] row_q, row_d;
  logic           s1_valid_q;
  lgs_pkg::s1_t   s1_q, tag;

  logic [WW-1:0]  w, col_n, col_inc, ocol_w;
  logic [RPW-1:0] h, row_n, orow_w;
  logic           flush, ignore;

  assign w = lgs_pkg::clamp_width(cfg_i.grid_width);
  assign h = RPW'(lgs_pkg::clamp_height(cfg_i.grid_height));

  always_comb begin
    // position of this item after the row wrap and the frame restart
    col_n = WW'(col_q);
    row_n = row_q;
    if (col_n >= w) begin
      col_n = '0;
      row_n = row_q + RPW'(1);
    end
    if (row_n > h + RPW'(1) || (row_n == h + RPW'(1) && col_n != '0)) begin
      row_n = '0;
      col_n = '0;
    end
    flush  = row_n >= h;
    ignore = item_i.drain && !flush;

    tag.v       = !flush && item_i.cell_alive;
    tag.addr    = col_n[CW-1:0];
    tag.has     = !(row_n == '0 || (row_n == RPW'(1) && col_n == '0));
    tag.at_edge = col_n == '0;
    // column zero reports the last cell of the row two up
    if (tag.at_edge) begin
      orow_w = row_n - RPW'(2);
      ocol_w = w - WW'(1);
    end else begin
      orow_w = row_n - RPW'(1);
      ocol_w = col_n - WW'(1);
    end
    tag.interior = !tag.at_edge && orow_w != '0 && (orow_w + RPW'(1)) < h &&
                   ocol_w != '0 && (ocol_w + WW'(1)) < w;
    tag.last     = tag.has && orow_w == h - RPW'(1) && ocol_w == w - WW'(1);
    tag.ocol     = ocol_w[CW-1:0];
    tag.orow     = orow_w[RW-1:0];

    col_inc = col_n + WW'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (accept_i) begin
      if (ignore) begin
        col_d = col_n[CW-1:0];
        row_d = row_n;
      end else if (tag.last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_inc >= w) begin
        col_d = '0;
        row_d = row_n + RPW'(1);
      end else begin
        col_d = col_inc[CW-1:0];
        row_d = row_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= accept_i && !ignore;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !ignore) s1_q <= tag;
  end

  assign ren_o      = accept_i && !ignore;
  assign raddr_o    = tag.addr;
  assign eaddr_o    = ocol_w[CW-1:0] & '1;
  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

endmodule

FILE: src/lgs_line_mem.sv
`timescale 1ns / 1ps

module lgs_line_mem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       ren_i,
  input  logic [lgs_pkg::CW-1:0]     raddr_i,
  input  logic [lgs_pkg::CW-1:0]     eaddr_i,
  input  lgs_pkg::line_wr_t          wr_i,
  output logic [lgs_pkg::CELL_W-1:0] rdata_o,
  output logic [lgs_pkg::CELL_W-1:0] edata_o
);

  localparam int WW = lgs_pkg::WW;

  logic [lgs_pkg::CELL_W-1:0] mem [lgs_pkg::MAX_WIDTH];
  logic [lgs_pkg::CELL_W-1:0] rdata_q, edata_q;
  // columns are written as a prefix from zero up, so entries past the fill read as zero
  logic [WW-1:0]              fill_q, fill_d;

  assign fill_d = (wr_i.we && WW'(wr_i.addr) == fill_q) ? fill_q + WW'(1) : fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fill_q <= '0;
    else         fill_q <= fill_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we) mem[wr_i.addr] <= wr_i.data;
  end

  // write-first: a read of the entry written at the same edge gets the new bits
  always_ff @(posedge clk_i) begin
    if (ren_i) begin
      if (wr_i.we && wr_i.addr == raddr_i)  rdata_q <= wr_i.data;
      else if (WW'(raddr_i) < fill_q)       rdata_q <= mem[raddr_i];
      else                                  rdata_q <= '0;
      if (wr_i.we && wr_i.addr == eaddr_i)  edata_q <= wr_i.data;
      else if (WW'(eaddr_i) < fill_q)       edata_q <= mem[eaddr_i];
      else                                  edata_q <= '0;
    end
  end

  assign rdata_o = rdata_q;
  assign edata_o = edata_q;

endmodule

FILE: src/lgs_out_fifo.sv
`timescale 1ns / 1ps

module lgs_out_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  lgs_pkg::out_item_t           data_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output lgs_pkg::out_item_t           data_o,
  output logic [lgs_pkg::OFIFO_CW-1:0] count_o
);

  localparam int PW = lgs_pkg::OFIFO_PW;
  localparam int NW = lgs_pkg::OFIFO_CW;

  lgs_pkg::out_item_t slots [lgs_pkg::OFIFO_DEPTH];
  logic [PW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]      count_q, count_d;
  logic               pop;

  assign pop     = valid_o && !stall_i;
  assign count_d = count_q + NW'(push_i) - NW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PW'(1);
      if (pop)    rd_ptr_q <= rd_ptr_q + PW'(1);
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slots[wr_ptr_q] <= data_i;
  end

  assign valid_o = count_q != '0;
  assign data_o  = slots[rd_ptr_q];
  assign count_o = count_q;

endmodule

FILE: src/lgs_checker.sv
`timescale 1ns / 1ps
`include "life_generation_stream_macros.svh"

module lgs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input lgs_pkg::out_item_t out_data_o
);

  `LGS_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")
  `LGS_ASSERT_IMP(a_stall_has_result, in_stall_o, out_valid_o, "input stalled with no result queued")
  `LGS_ASSERT_IMP(a_result_after_request, $rose(out_valid_o), $past(in_valid_i && !in_stall_o, 2), "result without a request two cycles back")
  `LGS_ASSERT_IMP(a_last_position, out_valid_o && out_data_o.frame_last, out_data_o.row >= (lgs_pkg::MIN_DIM - 1) && out_data_o.column >= (lgs_pkg::MIN_DIM - 1), "frame end at an impossible position")

endmodule

bind life_generation_stream lgs_checker u_lgs_checker (.*);
